FILE: hdl/pfps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfps_pkg
// Types and codes shared by the flow pipe scheduler and its queue cells.
// ----------------------------------------------------------------------------
package pfps_pkg;

  localparam int unsigned ID_W    = 10;
  localparam int unsigned PRI_W   = 4;
  localparam int unsigned STAMP_W = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned ORD_W   = 10;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned WCNT_W  = 6;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 24;

  // Sort key, most significant field first so a plain compare orders it
  typedef struct packed {
    logic [PRI_W-1:0]   priority_level;
    logic [STAMP_W-1:0] arrival_stamp;
    logic [LEN_W-1:0]   transmit_length;
    logic [ORD_W-1:0]   list_order;
  } sort_key_t;

  typedef struct packed {
    sort_key_t       key;
    logic [ID_W-1:0] flow_id;
  } wait_entry_t;

  // Queue operation broadcast to every cell
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctl_t;

  typedef enum logic [0:0] {
    MODE_REQUEST = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_GRANTED      = 3'd0,
    ST_QUEUED       = 3'd1,
    ST_RELEASED_NXT = 3'd2,
    ST_RELEASED_IDL = 3'd3,
    ST_ERROR        = 3'd4
  } status_t;

endpackage

FILE: hdl/priority_flow_pipe_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_flow_pipe_scheduler_unit
// Non-preemptive scheduler for one shared transmit pipe with a sorted queue.
// ----------------------------------------------------------------------------
// One request per clock cycle is accepted, and its result is presented in the
// output register on the following cycle. The waiting queue is a row of
// QUEUE_DEPTH compare cells: an insert is placed by all cells comparing their
// key with the new one in parallel, the cells behind it shifting one place
// right; a grant on release pops the head by shifting every cell one place
// left. The input is held off only while a result waits unread.
// ----------------------------------------------------------------------------
module priority_flow_pipe_scheduler_unit #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // flow_id, priority_level, arrival_stamp, transmit_length, list_order
  input  logic [pfps_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // mode
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // grant_valid, granted_flow, status, waiting_count, zero pad
  output logic [pfps_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                        accept;
  pfps_pkg::wait_entry_t       new_entry;
  pfps_pkg::cell_ctl_t         ctl;
  logic [CNT_W-1:0]            wait_count;
  logic [CNT_W-1:0]            wait_count_next;
  logic                        pipe_busy;
  logic                        pipe_busy_next;
  logic [pfps_pkg::ID_W-1:0]   current_flow;
  logic [pfps_pkg::ID_W-1:0]   current_flow_next;
  logic                        grant;
  logic [pfps_pkg::ID_W-1:0]   grant_flow;
  pfps_pkg::status_t           status;
  logic [CNT_W+5:0]            count_ext;

  pfps_pkg::wait_entry_t       entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]      keeps;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign new_entry.flow_id             = s_axis_tdata[9:0];
  assign new_entry.key.priority_level  = s_axis_tdata[13:10];
  assign new_entry.key.arrival_stamp   = s_axis_tdata[29:14];
  assign new_entry.key.transmit_length = s_axis_tdata[45:30];
  assign new_entry.key.list_order      = s_axis_tdata[55:46];

  always_comb begin
    ctl               = '0;
    wait_count_next   = wait_count;
    pipe_busy_next    = pipe_busy;
    current_flow_next = current_flow;
    grant             = 1'b0;
    grant_flow        = '0;
    status            = pfps_pkg::ST_ERROR;
    if (pfps_pkg::mode_t'(s_axis_tuser) == pfps_pkg::MODE_REQUEST) begin
      if (!pipe_busy && wait_count == '0) begin
        pipe_busy_next    = 1'b1;
        current_flow_next = new_entry.flow_id;
        grant             = 1'b1;
        grant_flow        = new_entry.flow_id;
        status            = pfps_pkg::ST_GRANTED;
      end else if (wait_count != CNT_W'(QUEUE_DEPTH)) begin
        ctl.insert      = 1'b1;
        wait_count_next = wait_count + 1'b1;
        status          = pfps_pkg::ST_QUEUED;
      end
    end else begin
      if (pipe_busy && wait_count == '0) begin
        pipe_busy_next = 1'b0;
        status         = pfps_pkg::ST_RELEASED_IDL;
      end else if (pipe_busy) begin
        ctl.pop           = 1'b1;
        wait_count_next   = wait_count - 1'b1;
        current_flow_next = entries[0].flow_id;
        grant             = 1'b1;
        grant_flow        = entries[0].flow_id;
        status            = pfps_pkg::ST_RELEASED_NXT;
      end
    end
    if (!accept) begin
      ctl = '0;
    end
  end

  assign count_ext = {6'b0, wait_count_next};

  // Queue: cell 0 is the head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    pfps_pkg::wait_entry_t left_entry;
    pfps_pkg::wait_entry_t right_entry;
    logic                  left_keep;
    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_keep  = 1'b1;
    end else begin : g_body
      assign left_entry = entries[i-1];
      assign left_keep  = keeps[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end
    pfps_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (CNT_W'(i) < wait_count),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .left_keep   (left_keep),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .keep        (keeps[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_count    <= '0;
      pipe_busy     <= 1'b0;
      current_flow  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        wait_count    <= wait_count_next;
        pipe_busy     <= pipe_busy_next;
        current_flow  <= current_flow_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result register, loaded with each accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {4'b0, count_ext[5:0], status, grant_flow, grant};
    end
  end

endmodule

FILE: hdl/pfps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfps_cell
// One slot of the sorted waiting queue: holds an entry, compares it with the
// incoming request and shifts towards either neighbour.
// ----------------------------------------------------------------------------
module pfps_cell (
  input  logic                  clk,
  input  pfps_pkg::cell_ctl_t   ctl,
  input  logic                  occupied,
  input  pfps_pkg::wait_entry_t new_entry,
  input  pfps_pkg::wait_entry_t left_entry,
  input  logic                  left_keep,
  input  pfps_pkg::wait_entry_t right_entry,
  output pfps_pkg::wait_entry_t entry,
  output logic                  keep
);

  // Equal keys stay ahead of the newcomer
  assign keep = occupied && (entry.key <= new_entry.key);

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (!keep) begin
        entry <= left_keep ? new_entry : left_entry;
      end
    end else if (ctl.pop) begin
      entry <= right_entry;
    end
  end

endmodule

FILE: tb/sv/priority_flow_pipe_scheduler_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_flow_pipe_scheduler_unit_test
// Self-checking bench for the flow pipe scheduler. Request and release items
// are streamed in with random gaps and output stalls. Each accepted item is
// run through a behavioural copy of the sorted waiting line, and every result
// is compared field by field with the oldest predicted outcome.
// ----------------------------------------------------------------------------
module priority_flow_pipe_scheduler_unit_test;

  localparam int unsigned QUEUE_DEPTH = 32;

  typedef struct {
    pfps_pkg::mode_t       mode;
    pfps_pkg::wait_entry_t ent;
    int unsigned           gap;
  } flow_cmd_t;

  typedef struct packed {
    logic                        grant;
    logic [pfps_pkg::ID_W-1:0]   flow;
    pfps_pkg::status_t           status;
    logic [pfps_pkg::WCNT_W-1:0] count;
  } outcome_t;

  logic                            clk;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [pfps_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [pfps_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  flow_cmd_t             flow_cmd_q[$];
  outcome_t              outcome_q[$];
  pfps_pkg::wait_entry_t wait_line[$];
  logic                      pipe_busy;
  logic [pfps_pkg::ID_W-1:0] current_flow;

  flow_cmd_t           staged;
  logic                have_staged;
  int unsigned         gap_left;
  logic                in_took;
  int unsigned         stall_left;
  int unsigned         calm_left;
  logic                sink_calm;
  int unsigned         fails;
  pfps_pkg::sort_key_t last_key;

  priority_flow_pipe_scheduler_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Apply one request or release to the waiting line and the pipe state
  function automatic outcome_t next_schedule_outcome(pfps_pkg::mode_t mode,
                                                     pfps_pkg::wait_entry_t ent);
    outcome_t              res;
    int                    pos;
    logic [45:0]           new_key;
    logic [45:0]           cur_key;
    pfps_pkg::wait_entry_t head;
    res.grant  = 1'b0;
    res.flow   = '0;
    res.status = pfps_pkg::ST_ERROR;
    new_key    = ent.key;
    if (mode == pfps_pkg::MODE_REQUEST) begin
      if (!pipe_busy && wait_line.size() == 0) begin
        pipe_busy    = 1'b1;
        current_flow = ent.flow_id;
        res.grant    = 1'b1;
        res.flow     = ent.flow_id;
        res.status   = pfps_pkg::ST_GRANTED;
      end else if (wait_line.size() < QUEUE_DEPTH) begin
        // equal keys go behind those already waiting
        pos = 0;
        while (pos < wait_line.size()) begin
          cur_key = wait_line[pos].key;
          if (cur_key > new_key) break;
          pos++;
        end
        wait_line.insert(pos, ent);
        res.status = pfps_pkg::ST_QUEUED;
      end
    end else if (pipe_busy) begin
      if (wait_line.size() == 0) begin
        pipe_busy  = 1'b0;
        res.status = pfps_pkg::ST_RELEASED_IDL;
      end else begin
        head         = wait_line.pop_front();
        current_flow = head.flow_id;
        res.grant    = 1'b1;
        res.flow     = head.flow_id;
        res.status   = pfps_pkg::ST_RELEASED_NXT;
      end
    end
    res.count = (pfps_pkg::WCNT_W)'(wait_line.size());
    return res;
  endfunction

  function automatic int unsigned pick_gap(logic calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_tick();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom_range(0, 3));
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_cmd(pfps_pkg::mode_t mode, logic [pfps_pkg::ID_W-1:0] flow,
                         logic [pfps_pkg::PRI_W-1:0] pri,
                         logic [pfps_pkg::STAMP_W-1:0] arr,
                         logic [pfps_pkg::LEN_W-1:0] len,
                         logic [pfps_pkg::ORD_W-1:0] ord, int unsigned gap);
    flow_cmd_t cmd;
    cmd.mode                         = mode;
    cmd.ent.flow_id                  = flow;
    cmd.ent.key.priority_level       = pri;
    cmd.ent.key.arrival_stamp        = arr;
    cmd.ent.key.transmit_length      = len;
    cmd.ent.key.list_order           = ord;
    cmd.gap                          = gap;
    flow_cmd_q.push_back(cmd);
  endtask

  task automatic add_random_cmd(int unsigned release_pct, logic calm);
    pfps_pkg::sort_key_t k;
    pfps_pkg::mode_t     mode;
    mode = ($urandom_range(0, 99) < release_pct) ? pfps_pkg::MODE_RELEASE
                                                 : pfps_pkg::MODE_REQUEST;
    if ($urandom_range(0, 9) == 0) begin
      k = last_key;
    end else begin
      k.priority_level  = ($urandom_range(0, 9) == 0)
                          ? (pfps_pkg::PRI_W)'($urandom)
                          : (pfps_pkg::PRI_W)'($urandom_range(1, 10));
      k.arrival_stamp   = pick_tick();
      k.transmit_length = pick_tick();
      k.list_order      = ($urandom_range(0, 2) == 0)
                          ? (pfps_pkg::ORD_W)'($urandom_range(0, 3))
                          : (pfps_pkg::ORD_W)'($urandom);
    end
    if (mode == pfps_pkg::MODE_REQUEST) last_key = k;
    add_cmd(mode, (pfps_pkg::ID_W)'($urandom), k.priority_level, k.arrival_stamp,
            k.transmit_length, k.list_order, pick_gap(calm));
  endtask

  // Monitor: check results, then predict for the request accepted at this edge
  always @(posedge clk) begin
    outcome_t              got;
    outcome_t              want;
    pfps_pkg::wait_entry_t ent;
    if (rst) begin
      in_took = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.grant  = m_axis_tdata[0];
        got.flow   = m_axis_tdata[10:1];
        got.status = pfps_pkg::status_t'(m_axis_tdata[13:11]);
        got.count  = m_axis_tdata[19:14];
        if (outcome_q.size() == 0) begin
          $error("result with no request pending: tdata %h", m_axis_tdata);
          fails++;
        end else begin
          want = outcome_q.pop_front();
          if (got.grant !== want.grant) begin
            $error("grant_valid: expected %0d, actual %0d", want.grant, got.grant);
            fails++;
          end
          if (got.flow !== want.flow) begin
            $error("granted_flow: expected %0d, actual %0d", want.flow, got.flow);
            fails++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fails++;
          end
          if (got.count !== want.count) begin
            $error("waiting_count: expected %0d, actual %0d", want.count, got.count);
            fails++;
          end
        end
      end
      in_took = s_axis_tvalid && s_axis_tready;
      if (in_took) begin
        ent.flow_id                  = s_axis_tdata[9:0];
        ent.key.priority_level       = s_axis_tdata[13:10];
        ent.key.arrival_stamp        = s_axis_tdata[29:14];
        ent.key.transmit_length      = s_axis_tdata[45:30];
        ent.key.list_order           = s_axis_tdata[55:46];
        outcome_q.push_back(next_schedule_outcome(pfps_pkg::mode_t'(s_axis_tuser), ent));
      end
    end
  end

  // Request driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_took) begin
      if (!have_staged && flow_cmd_q.size() != 0) begin
        staged      = flow_cmd_q.pop_front();
        have_staged = 1'b1;
        gap_left    = staged.gap;
      end
      if (have_staged && gap_left == 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= staged.mode;
        s_axis_tdata  <= {staged.ent.key.list_order, staged.ent.key.transmit_length,
                          staged.ent.key.arrival_stamp, staged.ent.key.priority_level,
                          staged.ent.flow_id};
        have_staged = 1'b0;
      end else begin
        if (have_staged) gap_left--;
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink with stalls; calm stretches hold ready high throughout
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (calm_left == 0) begin
        sink_calm = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(100, 400);
      end else begin
        calm_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap(sink_calm);
      end
    end
  end

  initial begin
    int unsigned phase_len;
    int unsigned release_pct;
    logic        calm;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    pipe_busy     = 1'b0;
    current_flow  = '0;
    have_staged   = 1'b0;
    gap_left      = 0;
    in_took       = 1'b0;
    stall_left    = 0;
    calm_left     = 0;
    sink_calm     = 1'b0;
    fails         = 0;
    last_key      = '0;

    // release with nothing on the pipe, then extremes of every field
    add_cmd(pfps_pkg::MODE_RELEASE, 10'h3FF, 4'hF, 16'hFFFF, 16'hFFFF, 10'h3FF,
            pick_gap(0));
    add_cmd(pfps_pkg::MODE_REQUEST, 10'h3FF, 4'hF, 16'hFFFF, 16'hFFFF, 10'h3FF,
            pick_gap(0));
    add_cmd(pfps_pkg::MODE_REQUEST, 10'h000, 4'h0, 16'h0000, 16'h0000, 10'h000,
            pick_gap(0));
    add_cmd(pfps_pkg::MODE_REQUEST, 10'h2AA, 4'hF, 16'hFFFF, 16'hFFFF, 10'h3FF,
            pick_gap(0));
    add_cmd(pfps_pkg::MODE_REQUEST, 10'h001, 4'h0, 16'h0000, 16'h0000, 10'h000,
            pick_gap(0));
    add_cmd(pfps_pkg::MODE_REQUEST, 10'h002, 4'd10, 16'd5, 16'd9, 10'd7, pick_gap(0));
    add_cmd(pfps_pkg::MODE_REQUEST, 10'h003, 4'd10, 16'd5, 16'd3, 10'd7, pick_gap(0));
    add_cmd(pfps_pkg::MODE_REQUEST, 10'h004, 4'd10, 16'd5, 16'd3, 10'd1, pick_gap(0));
    add_cmd(pfps_pkg::MODE_REQUEST, 10'h005, 4'd10, 16'd4, 16'hFFFF, 10'h3FF,
            pick_gap(0));
    add_cmd(pfps_pkg::MODE_REQUEST, 10'h155, 4'd1, 16'hFFFF, 16'h0000, 10'h3FF,
            pick_gap(0));
    for (int i = 0; i < 9; i++) begin
      add_cmd(pfps_pkg::MODE_RELEASE, (pfps_pkg::ID_W)'($urandom),
              (pfps_pkg::PRI_W)'($urandom), 16'($urandom), 16'($urandom),
              (pfps_pkg::ORD_W)'($urandom), pick_gap(0));
    end
    add_cmd(pfps_pkg::MODE_RELEASE, 10'h000, 4'h0, 16'h0000, 16'h0000, 10'h000,
            pick_gap(0));

    // phases that fill, drain or churn the waiting line
    while (flow_cmd_q.size() < 1050) begin
      case ($urandom_range(0, 2))
        0:       release_pct = 10;
        1:       release_pct = 85;
        default: release_pct = 50;
      endcase
      calm      = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 80);
      for (int i = 0; i < phase_len; i++) add_random_cmd(release_pct, calm);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (flow_cmd_q.size() != 0 || have_staged || s_axis_tvalid || outcome_q.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
